[sv/cgl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgl_pkg
// Shared types and constants for the coincidence group labeler.
// ----------------------------------------------------------------------------
package cgl_pkg;

    localparam int MAX_KEYS    = 16;
    localparam int KEY_CNT_W   = $clog2(MAX_KEYS + 1);
    localparam int KEY_IDX_W   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int TIME_W      = 64;
    localparam int ENERGY_W    = 32;
    localparam int GROUP_W     = 32;
    localparam int ID_W        = 5;
    localparam int S_TDATA_W   = 192;
    localparam int M_TDATA_W   = 48;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [TIME_W-1:0]   time_a;
        logic [ENERGY_W-1:0] energy_a;
        logic [TIME_W-1:0]   time_b;
        logic [ENERGY_W-1:0] energy_b;
        logic                same_ab;   // key b equals key a
    } t_item;

    typedef struct packed {
        logic [GROUP_W-1:0] group_number;
        logic [ID_W-1:0]    local_id_a;
        logic [ID_W-1:0]    local_id_b;
        logic               overflow;
    } t_result;

    // ids wider than the output field keep their low bits
    function automatic logic [ID_W-1:0] to_id(input logic [KEY_CNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[ID_W-1:0];
    endfunction

endpackage

[sv/cgl_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgl_front
// Accepts coincidences, flags identical key pairs and buffers them in a
// short queue ahead of the key table.
// ----------------------------------------------------------------------------
module cgl_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // time_a[63:0], energy_a[95:64], time_b[159:96], energy_b[191:160]
    input  logic [cgl_pkg::S_TDATA_W-1:0]  i_s_tdata,
    output logic                           o_valid,
    input  logic                           i_ready,
    output cgl_pkg::t_item                 o_item
);
    import cgl_pkg::*;

    t_item                  r_q [QUEUE_DEPTH];
    logic [QUEUE_CNT_W-1:0] r_fill, n_fill;
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    t_item                  w_in;
    logic                   w_push, w_pop;

    always_comb begin
        w_in.time_a   = i_s_tdata[63:0];
        w_in.energy_a = i_s_tdata[95:64];
        w_in.time_b   = i_s_tdata[159:96];
        w_in.energy_b = i_s_tdata[191:160];
        w_in.same_ab  = (i_s_tdata[95:0] == i_s_tdata[191:96]);
    end

    assign o_s_tready = (r_fill != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid    = (r_fill != '0);
    assign o_item     = r_q[r_rd_ptr];
    assign w_push     = i_s_tvalid && o_s_tready;
    assign w_pop      = o_valid && i_ready;

    always_comb begin
        n_fill = r_fill;
        if (w_push && !w_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!w_push && w_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_fill <= n_fill;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_in;
        end
    end

    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_ptr_gap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0 || r_fill == QUEUE_CNT_W'(QUEUE_DEPTH)) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with fill");

    a_fill_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_fill == $past(r_fill) + 1'b1)
        else $error("queue fill did not grow on push");

endmodule

[sv/cgl_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgl_back
// Key table for the current group: parallel match of both keys, group
// restart, insertion and the registered result stage.
// ----------------------------------------------------------------------------
module cgl_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  cgl_pkg::t_item        i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output cgl_pkg::t_result      o_result
);
    import cgl_pkg::*;

    logic [TIME_W-1:0]    r_key_time   [MAX_KEYS];
    logic [ENERGY_W-1:0]  r_key_energy [MAX_KEYS];
    logic [KEY_CNT_W-1:0] r_count, n_count;
    logic [GROUP_W-1:0]   r_group, n_group;
    logic                 r_out_valid;
    t_result              r_res, n_res;

    logic [MAX_KEYS-1:0]  w_hit_a, w_hit_b;
    logic [KEY_IDX_W-1:0] w_idx_a, w_idx_b;
    logic                 w_any_a, w_any_b, w_clear, w_pop;
    logic                 w_ins_a, w_ins_b, w_ovf;
    logic [KEY_CNT_W-1:0] w_base, w_cnt_a, w_id_a, w_id_b;

    assign w_pop   = i_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_out_valid || i_ready;

    // match both keys against every live entry at once
    always_comb begin
        for (int i = 0; i < MAX_KEYS; i++) begin
            w_hit_a[i] = (KEY_CNT_W'(i) < r_count)
                         && r_key_time[i] == i_item.time_a
                         && r_key_energy[i] == i_item.energy_a;
            w_hit_b[i] = (KEY_CNT_W'(i) < r_count)
                         && r_key_time[i] == i_item.time_b
                         && r_key_energy[i] == i_item.energy_b;
        end
        w_idx_a = '0;
        w_idx_b = '0;
        for (int i = MAX_KEYS - 1; i >= 0; i--) begin
            if (w_hit_a[i]) begin
                w_idx_a = KEY_IDX_W'(i);
            end
            if (w_hit_b[i]) begin
                w_idx_b = KEY_IDX_W'(i);
            end
        end
    end

    assign w_any_a = |w_hit_a;
    assign w_any_b = |w_hit_b;
    assign w_clear = (r_count != '0) && !w_any_a && !w_any_b;
    assign w_base  = w_clear ? '0 : r_count;

    always_comb begin
        w_ins_a = 1'b0;
        w_ins_b = 1'b0;
        w_ovf   = 1'b0;
        w_cnt_a = w_base;
        n_count = w_base;
        priority if (w_any_a) begin
            w_id_a = KEY_CNT_W'(w_idx_a);
        end else if (w_base < KEY_CNT_W'(MAX_KEYS)) begin
            w_id_a  = w_base;
            w_ins_a = 1'b1;
            w_cnt_a = w_base + 1'b1;
        end else begin
            w_id_a = KEY_CNT_W'(MAX_KEYS);
            w_ovf  = 1'b1;
        end
        n_count = w_cnt_a;
        // key b identical to key a shares its id, stored or not
        priority if (i_item.same_ab) begin
            w_id_b = w_id_a;
        end else if (w_any_b) begin
            w_id_b = KEY_CNT_W'(w_idx_b);
        end else if (w_cnt_a < KEY_CNT_W'(MAX_KEYS)) begin
            w_id_b  = w_cnt_a;
            w_ins_b = 1'b1;
            n_count = w_cnt_a + 1'b1;
        end else begin
            w_id_b = KEY_CNT_W'(MAX_KEYS);
            w_ovf  = 1'b1;
        end
    end

    assign n_group = r_group + GROUP_W'(w_clear);

    always_comb begin
        n_res.group_number = n_group;
        n_res.local_id_a   = to_id(w_id_a);
        n_res.local_id_b   = to_id(w_id_b);
        n_res.overflow     = w_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_group     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_count     <= n_count;
                r_group     <= n_group;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_res <= n_res;
            if (w_ins_a) begin
                r_key_time[w_base[KEY_IDX_W-1:0]]   <= i_item.time_a;
                r_key_energy[w_base[KEY_IDX_W-1:0]] <= i_item.energy_a;
            end
            if (w_ins_b) begin
                r_key_time[w_cnt_a[KEY_IDX_W-1:0]]   <= i_item.time_b;
                r_key_energy[w_cnt_a[KEY_IDX_W-1:0]] <= i_item.energy_b;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_res;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= KEY_CNT_W'(MAX_KEYS))
        else $error("key count above table size");

    a_idle_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_pop |=> $stable(r_group) && $stable(r_count))
        else $error("table state changed without a transaction");

    a_ovf_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_ovf) |=> r_count == KEY_CNT_W'(MAX_KEYS))
        else $error("overflow reported with room in the table");

    a_group_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_clear) |=> $stable(r_group))
        else $error("group advanced while a key matched");

endmodule

[sv/coincidence_group_labeler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coincidence_group_labeler
// Labels coincidences with a running group number and local hit ids.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (i_s_*) takes one coincidence per transaction: two hit keys,
//   each a 64-bit timestamp and a 32-bit energy pattern. Master channel
//   (o_m_*) returns one result per coincidence: group number, local id of
//   each key (16 = not stored) and an overflow flag, in input order.
//   Throughput is one coincidence per cycle while i_m_tready stays high: both
//   keys are matched against all 16 table entries in parallel and the table
//   is updated in the same cycle. An accepted transaction reaches o_m_tvalid
//   through the input queue register, then the result register.
//   A two-entry queue sits between the input and the table, so o_s_tready
//   only drops once that queue is full while the receiver stalls; the result
//   register holds its value until i_m_tready.
//   Reset (synchronous, active low) empties the queue and result register,
//   empties the key table and sets the group number to zero.
// ----------------------------------------------------------------------------
module coincidence_group_labeler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // time_a[63:0], energy_a[95:64], time_b[159:96], energy_b[191:160]
    input  logic [cgl_pkg::S_TDATA_W-1:0]  i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // group_number[31:0], local_id_a[36:32], local_id_b[41:37],
    // overflow[42], zero[47:43]
    output logic [cgl_pkg::M_TDATA_W-1:0]  o_m_tdata
);
    import cgl_pkg::*;

    t_item   w_item;
    t_result w_res;
    logic    w_q_valid, w_q_ready;

    cgl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_valid    (w_q_valid),
        .i_ready    (w_q_ready),
        .o_item     (w_item)
    );

    cgl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .o_ready  (w_q_ready),
        .i_item   (w_item),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_res)
    );

    assign o_m_tdata = {5'b0, w_res.overflow, w_res.local_id_b,
                        w_res.local_id_a, w_res.group_number};

endmodule
